### src/clht_pkg.sv
package clht_pkg;

  // Default number of channel records held by the table.
  localparam int unsigned ChannelsDef = 16;
  // Depth of the command queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Event codes as they arrive on the request channel.
  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_OPENED    = 4'd1,
    OP_DROPPED   = 4'd2,
    OP_RETRY_ERR = 4'd3,
    OP_RETRY_OK  = 4'd4,
    OP_FRAME     = 4'd5,
    OP_REMOVED   = 4'd6,
    OP_QUERY     = 4'd7,
    OP_QUERY_ALL = 4'd8,
    OP_RST_COUNT = 4'd9,
    OP_CLEAR     = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    LS_CONNECTING   = 3'd0,
    LS_STREAMING    = 3'd1,
    LS_RECONNECTING = 3'd2,
    LS_DEGRADED     = 3'd3,
    LS_FAILED       = 3'd4,
    LS_STOPPED      = 3'd5
  } link_e;

  typedef enum logic [1:0] {
    STAT_APPLIED = 2'd0,
    STAT_ABSENT  = 2'd1,
    STAT_FAILED  = 2'd2
  } status_e;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [3:0]  chan;
    logic        in_range;
    logic [15:0] degrade_limit;
    logic [15:0] fail_limit;
    logic [31:0] capture_time;
    logic [31:0] now_time;
  } cmd_t;

  // One channel record as held in the record memory.
  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] changed_at;
    logic [15:0] fail_run;
    logic [15:0] reconnects;
    logic [15:0] degrade_limit;
    logic [15:0] fail_limit;
    logic [31:0] frame_time;
    logic [31:0] frame_count;
  } rec_t;

endpackage

### src/channel_link_health_tracker_top.sv
// Channel    Direction  Handshake               Payload
// request    in         in_valid_i / in_stall_o  func, channel, limits, capture and now times
// result     out        out_valid_o / out_stall_i channel record, status, last
//
// In the back end a single-channel event first pops the command and reads the
// record memory, then applies the rules and writes back.
// Query all walks the channels in order and reads each present one through the
// single read port of the record memory.
// Reset clears the present and counter-cleared flags at once; no clearing pass.
// A stalled result holds the back end; the two-entry queue keeps taking
// requests until it fills, and then the request side stalls.
module channel_link_health_tracker_top import clht_pkg::*; #(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  func_i,
  input  logic [3:0]  channel_i,
  input  logic [15:0] degrade_limit_i,
  input  logic [15:0] fail_limit_i,
  input  logic [31:0] capture_time_i,
  input  logic [31:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_channel_o,
  output logic        present_o,
  output logic [2:0]  link_state_o,
  output logic [31:0] changed_at_o,
  output logic [15:0] fail_run_o,
  output logic [15:0] reconnects_o,
  output logic [31:0] last_frame_time_o,
  output logic [31:0] frames_seen_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  // The front decodes each request and checks the channel range; unused
  // event codes are taken and dropped here since they produce no result.
  // Classified commands wait in a short queue, so a stalled result does
  // not immediately stall the request side.
  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic empty;
  cmd_t pop_cmd;

  clht_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .channel_i      (channel_i),
    .degrade_limit_i(degrade_limit_i),
    .fail_limit_i   (fail_limit_i),
    .capture_time_i (capture_time_i),
    .now_time_i     (now_time_i),
    .full_i         (full),
    .push_o         (push),
    .push_cmd_o     (push_cmd)
  );

  clht_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .pop_cmd_o (pop_cmd)
  );

  // The back end owns the record memory and the per-channel flags, applies
  // the link rules, and walks the table for query all. Clear and counter
  // reset act on every channel at once through the flag vectors.
  clht_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .cmd_i            (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .present_o        (present_o),
    .link_state_o     (link_state_o),
    .changed_at_o     (changed_at_o),
    .fail_run_o       (fail_run_o),
    .reconnects_o     (reconnects_o),
    .last_frame_time_o(last_frame_time_o),
    .frames_seen_o    (frames_seen_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule

### src/clht_front.sv
module clht_front import clht_pkg::*; #(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  func_i,
  input  logic [3:0]  channel_i,
  input  logic [15:0] degrade_limit_i,
  input  logic [15:0] fail_limit_i,
  input  logic [31:0] capture_time_i,
  input  logic [31:0] now_time_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        push_cmd_o
);

  logic known;

  // Codes above clear are taken and dropped, since they yield no result.
  assign known      = (func_i <= OP_CLEAR);
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && known;

  always_comb begin
    push_cmd_o.op            = op_e'(func_i);
    push_cmd_o.chan          = channel_i;
    push_cmd_o.in_range      = (int'(channel_i) < int'(CHANNELS));
    push_cmd_o.degrade_limit = degrade_limit_i;
    push_cmd_o.fail_limit    = fail_limit_i;
    push_cmd_o.capture_time  = capture_time_i;
    push_cmd_o.now_time      = now_time_i;
  end

endmodule

### src/clht_queue.sv
module clht_queue import clht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### src/clht_back.sv
module clht_back import clht_pkg::*; #(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_channel_o,
  output logic        present_o,
  output logic [2:0]  link_state_o,
  output logic [31:0] changed_at_o,
  output logic [15:0] fail_run_o,
  output logic [15:0] reconnects_o,
  output logic [31:0] last_frame_time_o,
  output logic [31:0] frames_seen_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW = $clog2(CHANNELS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_WEXEC
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [CW-1:0]       walk_q, walk_d;
  logic [CHANNELS-1:0] valid_q, valid_d;
  // A set bit means the frame counter of that entry reads as zero.
  logic [CHANNELS-1:0] zero_q, zero_d;

  logic                out_valid_q, out_valid_d;
  logic [3:0]          out_chan_q, out_chan_d;
  logic                out_present_q, out_present_d;
  rec_t                out_rec_q, out_rec_d;
  status_e             out_status_q, out_status_d;
  logic                out_last_q, out_last_d;

  rec_t                rec_mem [CHANNELS];
  rec_t                rd_rec_q;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;

  logic [AW-1:0]       addr;
  logic [AW-1:0]       walk_addr;
  logic                here;
  logic                slot_free;
  logic                above;
  rec_t                cur;
  rec_t                nxt;
  rec_t                walk_rec;
  rec_t                absent;
  logic [15:0]         fail_inc;
  status_e             stat;
  logic                show;
  logic                do_wr;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign addr      = AW'(cmd_q.chan);
  assign walk_addr = walk_q[AW-1:0];
  assign here      = cmd_q.in_range && valid_q[addr];

  always_comb begin
    absent             = '0;
    absent.state       = LS_STOPPED;
    cur                = rd_rec_q;
    cur.frame_count    = zero_q[addr] ? '0 : rd_rec_q.frame_count;
    walk_rec           = rd_rec_q;
    walk_rec.frame_count = zero_q[walk_addr] ? '0 : rd_rec_q.frame_count;
    fail_inc           = (cur.fail_run != '1) ? cur.fail_run + 1'b1 : cur.fail_run;
  end

  // Any present channel above the walk position decides the final flag.
  always_comb begin
    above = 1'b0;
    for (int j = 0; j < int'(CHANNELS); j++) begin
      if (valid_q[j] && (j > int'(walk_q))) begin
        above = 1'b1;
      end
    end
  end

  // Event rules for one named channel.
  always_comb begin
    nxt   = cur;
    stat  = STAT_APPLIED;
    show  = here;
    do_wr = 1'b0;
    case (cmd_q.op)
      OP_ADD: begin
        if (cmd_q.in_range) begin
          nxt.state         = LS_CONNECTING;
          nxt.changed_at    = cmd_q.now_time;
          nxt.degrade_limit = cmd_q.degrade_limit;
          nxt.fail_limit    = cmd_q.fail_limit;
          nxt.frame_time    = '0;
          nxt.frame_count   = '0;
          if (!here) begin
            nxt.fail_run   = '0;
            nxt.reconnects = '0;
          end
          show  = 1'b1;
          do_wr = 1'b1;
        end else begin
          stat = STAT_ABSENT;
        end
      end
      OP_CLEAR: begin
        show = 1'b0;
      end
      OP_RST_COUNT: begin
        nxt.frame_count = '0;
      end
      default: begin
        if (!here) begin
          stat = STAT_ABSENT;
        end else if (cmd_q.op == OP_FRAME) begin
          nxt.frame_time  = cmd_q.capture_time;
          nxt.frame_count = cur.frame_count + 1'b1;
          do_wr           = 1'b1;
        end else if (cmd_q.op == OP_QUERY) begin
          do_wr = 1'b0;
        end else if (cur.state == LS_FAILED) begin
          stat = STAT_FAILED;
        end else begin
          do_wr = 1'b1;
          case (cmd_q.op)
            OP_OPENED: begin
              if (cur.state == LS_CONNECTING) begin
                nxt.state      = LS_STREAMING;
                nxt.changed_at = cmd_q.now_time;
              end
            end
            OP_DROPPED: begin
              if (cur.state == LS_STREAMING || cur.state == LS_CONNECTING) begin
                nxt.state      = LS_RECONNECTING;
                nxt.changed_at = cmd_q.now_time;
              end
            end
            OP_RETRY_ERR: begin
              nxt.fail_run = fail_inc;
              if (cur.fail_limit != '0 && fail_inc >= cur.fail_limit) begin
                nxt.state      = LS_FAILED;
                nxt.changed_at = cmd_q.now_time;
              end else if (fail_inc >= cur.degrade_limit && cur.state != LS_DEGRADED) begin
                nxt.state      = LS_DEGRADED;
                nxt.changed_at = cmd_q.now_time;
              end
            end
            OP_RETRY_OK: begin
              nxt.state      = LS_STREAMING;
              nxt.changed_at = cmd_q.now_time;
              nxt.fail_run   = '0;
              if (cur.reconnects != '1) begin
                nxt.reconnects = cur.reconnects + 1'b1;
              end
            end
            default: begin
              nxt.state      = LS_STOPPED;
              nxt.changed_at = cmd_q.now_time;
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    walk_d        = walk_q;
    valid_d       = valid_q;
    zero_d        = zero_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_chan_d    = out_chan_q;
    out_present_d = out_present_q;
    out_rec_d     = out_rec_q;
    out_status_d  = out_status_q;
    out_last_d    = out_last_q;
    pop_o         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.op == OP_QUERY_ALL) begin
            walk_d  = '0;
            state_d = S_WALK;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(cmd_i.chan);
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_chan_d    = cmd_q.chan;
          out_present_d = show;
          out_rec_d     = show ? nxt : absent;
          out_status_d  = stat;
          out_last_d    = 1'b1;
          if (do_wr) begin
            wr_en         = 1'b1;
            valid_d[addr] = 1'b1;
            zero_d[addr]  = 1'b0;
          end
          if (cmd_q.op == OP_CLEAR) begin
            valid_d = '0;
          end
          if (cmd_q.op == OP_RST_COUNT) begin
            zero_d = '1;
          end
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (walk_q == CW'(CHANNELS)) begin
          state_d = S_IDLE;
        end else if (valid_q[walk_addr]) begin
          rd_en   = 1'b1;
          rd_addr = walk_addr;
          state_d = S_WEXEC;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      S_WEXEC: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_chan_d    = 4'(walk_q);
          out_present_d = 1'b1;
          out_rec_d     = walk_rec;
          out_status_d  = STAT_APPLIED;
          out_last_d    = !above;
          walk_d        = walk_q + 1'b1;
          state_d       = S_WALK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_q      <= '0;
      valid_q     <= '0;
      zero_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      valid_q     <= valid_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    out_chan_q    <= out_chan_d;
    out_present_q <= out_present_d;
    out_rec_q     <= out_rec_d;
    out_status_q  <= out_status_d;
    out_last_q    <= out_last_d;
  end

  // Record memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[addr] <= nxt;
    end
    if (rd_en) begin
      rd_rec_q <= rec_mem[rd_addr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_channel_o     = out_chan_q;
  assign present_o         = out_present_q;
  assign link_state_o      = out_rec_q.state;
  assign changed_at_o      = out_rec_q.changed_at;
  assign fail_run_o        = out_rec_q.fail_run;
  assign reconnects_o      = out_rec_q.reconnects;
  assign last_frame_time_o = out_rec_q.frame_time;
  assign frames_seen_o     = out_rec_q.frame_count;
  assign status_o          = out_status_q;
  assign last_o            = out_last_q;

endmodule

### test/link_health_checker.sv
`timescale 1ns / 100ps

module link_health_checker import clht_pkg::*; #(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [3:0]  func_i,
  input  logic [3:0]  channel_i,
  input  logic [15:0] degrade_limit_i,
  input  logic [15:0] fail_limit_i,
  input  logic [31:0] capture_time_i,
  input  logic [31:0] now_time_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  out_channel_i,
  input  logic        present_i,
  input  logic [2:0]  link_state_i,
  input  logic [31:0] changed_at_i,
  input  logic [15:0] fail_run_i,
  input  logic [15:0] reconnects_i,
  input  logic [31:0] last_frame_time_i,
  input  logic [31:0] frames_seen_i,
  input  logic [1:0]  status_i,
  input  logic        last_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  typedef struct {
    logic [3:0]  chan;
    logic        present;
    link_e       state;
    logic [31:0] changed_at;
    logic [15:0] fail_run;
    logic [15:0] reconnects;
    logic [31:0] frame_time;
    logic [31:0] frame_count;
    status_e     status;
    logic        last;
  } health_rec_t;

  // Shadow copy of the channel table.
  logic        present_q     [CHANNELS];
  link_e       state_q       [CHANNELS];
  logic [31:0] changed_at_q  [CHANNELS];
  logic [15:0] fail_run_q    [CHANNELS];
  logic [15:0] reconnects_q  [CHANNELS];
  logic [15:0] degrade_lim_q [CHANNELS];
  logic [15:0] fail_lim_q    [CHANNELS];
  logic [31:0] frame_time_q  [CHANNELS];
  logic [31:0] frame_count_q [CHANNELS];

  health_rec_t expected_records[$];
  health_rec_t oldest;
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;

  initial begin
    for (int unsigned i = 0; i < CHANNELS; i++) begin
      present_q[i]     = 1'b0;
      state_q[i]       = LS_CONNECTING;
      changed_at_q[i]  = '0;
      fail_run_q[i]    = '0;
      reconnects_q[i]  = '0;
      degrade_lim_q[i] = '0;
      fail_lim_q[i]    = '0;
      frame_time_q[i]  = '0;
      frame_count_q[i] = '0;
    end
  end

  function automatic health_rec_t snapshot(int unsigned idx, status_e st, logic lst);
    health_rec_t r;
    logic        here;
    here         = (idx < CHANNELS) ? present_q[idx] : 1'b0;
    r.chan       = idx[3:0];
    r.present    = here;
    r.state      = here ? state_q[idx] : LS_STOPPED;
    r.changed_at = here ? changed_at_q[idx] : '0;
    r.fail_run   = here ? fail_run_q[idx] : '0;
    r.reconnects = here ? reconnects_q[idx] : '0;
    r.frame_time = here ? frame_time_q[idx] : '0;
    r.frame_count = here ? frame_count_q[idx] : '0;
    r.status     = st;
    r.last       = lst;
    return r;
  endfunction

  task automatic move_to(int unsigned idx, link_e st, logic [31:0] now);
    state_q[idx]      = st;
    changed_at_q[idx] = now;
  endtask

  // Applies one accepted request to the shadow table and queues the records it reports.
  task automatic predict_event(logic [3:0] f, logic [3:0] ch, logic [15:0] dlim,
                               logic [15:0] flim, logic [31:0] cap, logic [31:0] now);
    int unsigned idx;
    int unsigned i;
    int unsigned n;
    logic        here;
    status_e     st;
    health_rec_t r;
    idx  = ch;
    here = (idx < CHANNELS) ? present_q[idx] : 1'b0;
    st   = STAT_APPLIED;
    if (f > OP_CLEAR) return;

    if (f == OP_QUERY_ALL) begin
      n = 0;
      for (i = 0; i < CHANNELS; i++) begin
        if (present_q[i]) begin
          expected_records.push_back(snapshot(i, STAT_APPLIED, 1'b0));
          n++;
        end
      end
      if (n > 0) begin
        r = expected_records.pop_back();
        r.last = 1'b1;
        expected_records.push_back(r);
      end
      return;
    end

    if (f == OP_RST_COUNT) begin
      for (i = 0; i < CHANNELS; i++) begin
        if (present_q[i]) frame_count_q[i] = '0;
      end
      expected_records.push_back(snapshot(idx, STAT_APPLIED, 1'b1));
      return;
    end

    if (f == OP_CLEAR) begin
      for (i = 0; i < CHANNELS; i++) present_q[i] = 1'b0;
      expected_records.push_back(snapshot(idx, STAT_APPLIED, 1'b1));
      return;
    end

    if (f == OP_ADD) begin
      if (idx >= CHANNELS) begin
        expected_records.push_back(snapshot(idx, STAT_ABSENT, 1'b1));
        return;
      end
      if (!here) begin
        fail_run_q[idx]   = '0;
        reconnects_q[idx] = '0;
      end
      present_q[idx]     = 1'b1;
      move_to(idx, LS_CONNECTING, now);
      degrade_lim_q[idx] = dlim;
      fail_lim_q[idx]    = flim;
      frame_time_q[idx]  = '0;
      frame_count_q[idx] = '0;
      expected_records.push_back(snapshot(idx, STAT_APPLIED, 1'b1));
      return;
    end

    if (!here) begin
      expected_records.push_back(snapshot(idx, STAT_ABSENT, 1'b1));
      return;
    end

    if (f == OP_FRAME) begin
      frame_time_q[idx]  = cap;
      frame_count_q[idx] = frame_count_q[idx] + 32'd1;
    end else if (f == OP_QUERY) begin
      st = STAT_APPLIED;
    end else if (state_q[idx] == LS_FAILED) begin
      st = STAT_FAILED;
    end else if (f == OP_OPENED) begin
      if (state_q[idx] == LS_CONNECTING) move_to(idx, LS_STREAMING, now);
    end else if (f == OP_DROPPED) begin
      if (state_q[idx] == LS_STREAMING || state_q[idx] == LS_CONNECTING) begin
        move_to(idx, LS_RECONNECTING, now);
      end
    end else if (f == OP_RETRY_ERR) begin
      if (fail_run_q[idx] != 16'hFFFF) fail_run_q[idx] = fail_run_q[idx] + 16'd1;
      if (fail_lim_q[idx] != '0 && fail_run_q[idx] >= fail_lim_q[idx]) begin
        move_to(idx, LS_FAILED, now);
      end else if (fail_run_q[idx] >= degrade_lim_q[idx] && state_q[idx] != LS_DEGRADED) begin
        move_to(idx, LS_DEGRADED, now);
      end
    end else if (f == OP_RETRY_OK) begin
      move_to(idx, LS_STREAMING, now);
      fail_run_q[idx] = '0;
      if (reconnects_q[idx] != 16'hFFFF) reconnects_q[idx] = reconnects_q[idx] + 16'd1;
    end else begin
      move_to(idx, LS_STOPPED, now);
    end
    expected_records.push_back(snapshot(idx, st, 1'b1));
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CHANNELS; i++) present_q[i] = 1'b0;
      expected_records.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_event(func_i, channel_i, degrade_limit_i, fail_limit_i,
                      capture_time_i, now_time_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_records.size() == 0) begin
          $error("result for channel %0d arrived with nothing expected", out_channel_i);
          mismatches++;
        end else begin
          oldest = expected_records.pop_front();
          compare_field("out_channel", oldest.chan, out_channel_i);
          compare_field("present", oldest.present, present_i);
          compare_field("link_state", oldest.state, link_state_i);
          compare_field("changed_at", oldest.changed_at, changed_at_i);
          compare_field("fail_run", oldest.fail_run, fail_run_i);
          compare_field("reconnects", oldest.reconnects, reconnects_i);
          compare_field("last_frame_time", oldest.frame_time, last_frame_time_i);
          compare_field("frames_seen", oldest.frame_count, frames_seen_i);
          compare_field("status", oldest.status, status_i);
          compare_field("last", oldest.last, last_i);
        end
      end
    end
    outstanding = expected_records.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import clht_pkg::*;

  // Event codes above clear are not decoded by the block and produce no result.
  localparam logic [3:0] FirstUnusedCode = 4'd11;
  localparam logic [3:0] LastUnusedCode  = 4'd15;
  // Number of decoded requests sent after the directed part.
  localparam int unsigned RandomEvents = 430;
  // From this many random requests on, neither side idles any more.
  localparam int unsigned CalmFrom = 370;
  // Cycles allowed after the last expected record, enough for a full table walk.
  localparam int unsigned DrainCycles = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  func_i = '0;
  logic [3:0]  channel_i = '0;
  logic [15:0] degrade_limit_i = '0;
  logic [15:0] fail_limit_i = '0;
  logic [31:0] capture_time_i = '0;
  logic [31:0] now_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  out_channel_o;
  logic        present_o;
  logic [2:0]  link_state_o;
  logic [31:0] changed_at_o;
  logic [15:0] fail_run_o;
  logic [15:0] reconnects_o;
  logic [31:0] last_frame_time_o;
  logic [31:0] frames_seen_o;
  logic [1:0]  status_o;
  logic        last_o;

  int unsigned mismatch_count;
  int unsigned outstanding;

  // Stimulus bookkeeping. The calm flag switches off idling on both sides for the tail
  // of the run, idle_pct sets how often the request side inserts a gap.
  logic        calm = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned events_done = 0;
  logic [31:0] tick = '0;

  channel_link_health_tracker_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .channel_i         (channel_i),
    .degrade_limit_i   (degrade_limit_i),
    .fail_limit_i      (fail_limit_i),
    .capture_time_i    (capture_time_i),
    .now_time_i        (now_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_channel_o     (out_channel_o),
    .present_o         (present_o),
    .link_state_o      (link_state_o),
    .changed_at_o      (changed_at_o),
    .fail_run_o        (fail_run_o),
    .reconnects_o      (reconnects_o),
    .last_frame_time_o (last_frame_time_o),
    .frames_seen_o     (frames_seen_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

  // The checker sees both channels exactly as the block does and keeps the verdict data.
  link_health_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .func_i            (func_i),
    .channel_i         (channel_i),
    .degrade_limit_i   (degrade_limit_i),
    .fail_limit_i      (fail_limit_i),
    .capture_time_i    (capture_time_i),
    .now_time_i        (now_time_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_channel_i     (out_channel_o),
    .present_i         (present_o),
    .link_state_i      (link_state_o),
    .changed_at_i      (changed_at_o),
    .fail_run_i        (fail_run_o),
    .reconnects_i      (reconnects_o),
    .last_frame_time_i (last_frame_time_o),
    .frames_seen_i     (frames_seen_o),
    .status_i          (status_o),
    .last_i            (last_o),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Presents one request and holds it until the block takes it. Valid stays high into
  // the next request unless a gap is drawn, so back-to-back requests see no bubble.
  task automatic send_event(logic [3:0] f, logic [3:0] ch, logic [15:0] dlim,
                            logic [15:0] flim, logic [31:0] cap, logic [31:0] now);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    channel_i       <= ch;
    degrade_limit_i <= dlim;
    fail_limit_i    <= flim;
    capture_time_i  <= cap;
    now_time_i      <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Requests with an unused code are ignored by the block and are not counted.
    if (f <= OP_CLEAR) events_done++;
  endtask

  // A link event with a time stamp that mostly moves forward. Now and then a fully random
  // stamp is used so that every bit of the time field toggles. The limit and capture
  // fields carry random values; the block must ignore them outside add and frame.
  task automatic link_event(logic [3:0] f, logic [3:0] ch);
    logic [31:0] now;
    tick = tick + $urandom_range(1, 500);
    now  = ($urandom_range(0, 9) == 0) ? $urandom : tick;
    send_event(f, ch, 16'($urandom), 16'($urandom), $urandom, now);
  endtask

  // Adds a channel with thresholds small enough that retry failures reach the degraded and
  // failed states within a short sequence. A few adds use full-range thresholds.
  task automatic add_channel(logic [3:0] ch);
    logic [15:0] dlim;
    logic [15:0] flim;
    if ($urandom_range(0, 99) < 85) begin
      dlim = 16'($urandom_range(0, 4));
      flim = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    end else begin
      dlim = 16'($urandom);
      flim = 16'($urandom);
    end
    tick = tick + $urandom_range(1, 500);
    send_event(OP_ADD, ch, dlim, flim, $urandom, tick);
  endtask

  // Result side: runs of acceptance broken by stall bursts, and no stalls at all
  // once the calm tail of the run has begun.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
        if (!calm) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 7)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned steps;
    int unsigned roll;
    logic [3:0]  ch;
    logic [3:0]  target;
    op_e         op;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. It starts with an empty table, so query all must produce nothing
    // and an event on a channel that was never added reports the channel as absent.
    idle_pct = 30;
    link_event(OP_QUERY_ALL, 4'd0);
    link_event(OP_OPENED, 4'd3);
    link_event(FirstUnusedCode, 4'd3);
    link_event(LastUnusedCode, 4'd15);
    // Extremes of the add fields: zero thresholds and zero time, then all ones.
    send_event(OP_ADD, 4'd0, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_event(OP_ADD, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    link_event(OP_OPENED, 4'd0);
    send_event(OP_FRAME, 4'd0, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h1234_5678);
    send_event(OP_FRAME, 4'd0, 16'h0, 16'h0, 32'h0, 32'h1234_5679);
    // With a zero degrade limit the first failure degrades, the second leaves it there.
    link_event(OP_DROPPED, 4'd0);
    link_event(OP_RETRY_ERR, 4'd0);
    link_event(OP_RETRY_ERR, 4'd0);
    link_event(OP_RETRY_OK, 4'd0);
    // Re-adding a present channel keeps its failure and reconnect counts.
    send_event(OP_ADD, 4'd0, 16'd1, 16'd2, 32'h0, 32'h0000_1000);
    link_event(OP_RETRY_ERR, 4'd0);
    link_event(OP_RETRY_ERR, 4'd0);
    // The channel has failed: link events are refused, frames and queries still work.
    link_event(OP_OPENED, 4'd0);
    link_event(OP_DROPPED, 4'd0);
    link_event(OP_RETRY_OK, 4'd0);
    link_event(OP_REMOVED, 4'd0);
    link_event(OP_FRAME, 4'd0);
    link_event(OP_QUERY, 4'd0);
    link_event(OP_QUERY_ALL, 4'd9);
    // Counter reset and clear report applied even when the named channel is absent.
    link_event(OP_RST_COUNT, 4'd7);
    link_event(OP_REMOVED, 4'd15);
    link_event(OP_CLEAR, 4'd15);
    link_event(OP_QUERY, 4'd0);
    link_event(OP_ADD, 4'd0);

    // Random part. Most of it is episodes that add a channel and then drive it through a
    // plausible life of link events, with some events aimed at other channels. The rest
    // is noise with every field random, unused codes included.
    random_start = events_done;
    while (events_done - random_start < RandomEvents) begin
      if (events_done - random_start >= CalmFrom) calm = 1'b1;
      if ($urandom_range(0, 99) < 80) begin
        ch       = 4'($urandom_range(0, 15));
        idle_pct = ($urandom_range(0, 1) == 0) ? 35 : 0;
        if ($urandom_range(0, 3) != 0) add_channel(ch);
        steps = $urandom_range(4, 14);
        repeat (steps) begin
          roll   = $urandom_range(0, 99);
          target = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : ch;
          if (roll < 14)      op = OP_OPENED;
          else if (roll < 32) op = OP_FRAME;
          else if (roll < 46) op = OP_DROPPED;
          else if (roll < 71) op = OP_RETRY_ERR;
          else if (roll < 82) op = OP_RETRY_OK;
          else if (roll < 93) op = OP_QUERY;
          else                op = OP_REMOVED;
          link_event(op, target);
        end
        roll = $urandom_range(0, 99);
        if (roll < 30)      link_event(OP_QUERY_ALL, 4'($urandom_range(0, 15)));
        else if (roll < 40) link_event(OP_RST_COUNT, 4'($urandom_range(0, 15)));
        else if (roll < 44) link_event(OP_CLEAR, 4'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_event(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'($urandom),
                     16'($urandom), $urandom, $urandom);
        end
      end
    end
    in_valid_i <= 1'b0;

    // Let the last request reach the checker, drain every expected record, then give
    // the block time to show any stray extra record before the verdict.
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, including full table walks and the
  // longest stalls on both sides.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
